### hdl/tws_pkg.sv
// Shared widths, register indexes and mode codes for the texture wrap sampler.
// No dependencies; compiled first.
package tws_pkg;

   localparam int COORD_W        = 24;   // signed coordinate and shift width
   localparam int RGB_W          = 24;   // packed 8-bit R, G, B
   localparam int INDEX_W        = 16;   // texel position of a load
   localparam int SIZE_W         = 9;    // image width and height registers
   localparam int MODE_W         = 2;
   localparam int DIV_W          = SIZE_W + 1;           // twice the size
   localparam int PROD_W         = COORD_W + 2 + DIV_W;  // coordinate times size
   localparam int REM_STEP       = 4;    // remainder bits resolved per stage
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 5;
   localparam int CSR_SEL_W      = CSR_ADDR_W - 2;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_FRAC_BITS  = 16;
   localparam int RESET_SIZE     = 256;

   typedef enum logic [CSR_SEL_W-1:0] {
      REG_IMAGE_WIDTH    = 3'd0,
      REG_IMAGE_HEIGHT   = 3'd1,
      REG_WRAP_MODE      = 3'd2,
      REG_BACKGROUND_RGB = 3'd3,
      REG_SHIFT_X        = 3'd4,
      REG_SHIFT_Y        = 3'd5
   } reg_index_type;

   typedef enum logic {
      ACT_LOAD   = 1'b0,
      ACT_LOOKUP = 1'b1
   } action_type;

   localparam logic [MODE_W-1:0] WRAP_BACKGROUND = 2'd0;
   localparam logic [MODE_W-1:0] WRAP_TILE       = 2'd1;
   localparam logic [MODE_W-1:0] WRAP_MIRROR     = 2'd2;

endpackage

### hdl/tws_chan_if.sv
// Valid/ready channel interfaces for requests and responses of the sampler.
// Depends on tws_pkg for field widths.
interface tws_req_if import tws_pkg::*; ();
   logic                      valid;
   logic                      ready;
   action_type                action;
   logic [INDEX_W-1:0]        texel_index;
   logic [RGB_W-1:0]          texel_rgb;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;

   modport source (output valid, action, texel_index, texel_rgb, coord_x, coord_y,
                   input ready);
   modport sink   (input valid, action, texel_index, texel_rgb, coord_x, coord_y,
                   output ready);
endinterface

interface tws_rsp_if import tws_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RGB_W-1:0] color_rgb;
   logic             from_background;

   modport source (output valid, color_rgb, from_background, input ready);
   modport sink   (input valid, color_rgb, from_background, output ready);
endinterface

### hdl/tws_rem.sv
// Pipelined remainder unit: magnitude modulo a divisor, REM_STEP bits per stage.
// Depends on tws_pkg; each stage advances on its own enable.
module tws_rem import tws_pkg::*; #(
   parameter int MAG_W  = 21,
   parameter int STAGES = (MAG_W + REM_STEP - 1) / REM_STEP
) (
   input  logic              clock,
   input  logic [STAGES-1:0] advance,
   input  logic [MAG_W-1:0]  value,
   input  logic [DIV_W-1:0]  divisor,
   output logic [DIV_W-1:0]  remainder
);

   localparam int PAD_W = STAGES * REM_STEP;

   logic [DIV_W-1:0] rem_ff [STAGES];
   logic [DIV_W-1:0] rem_in [STAGES];
   logic [PAD_W-1:0] mag_ff [STAGES];
   logic [PAD_W-1:0] mag_in [STAGES];
   logic [PAD_W-1:0] value_pad;

   // restoring remainder over a group of bits, most significant first
   function automatic logic [DIV_W-1:0] rem_step(logic [DIV_W-1:0] r,
                                                 logic [REM_STEP-1:0] bits,
                                                 logic [DIV_W-1:0] d);
      logic [DIV_W:0]   t;
      logic [DIV_W-1:0] acc;
      acc = r;
      for (int b = REM_STEP - 1; b >= 0; b--) begin
         t = {acc, bits[b]};
         if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
         end
         acc = t[DIV_W-1:0];
      end
      return acc;
   endfunction

   assign value_pad = PAD_W'(value);

   always_comb begin
      rem_in[0] = rem_step('0, value_pad[PAD_W-1 -: REM_STEP], divisor);
      mag_in[0] = value_pad << REM_STEP;
      for (int k = 1; k < STAGES; k++) begin
         rem_in[k] = rem_step(rem_ff[k-1], mag_ff[k-1][PAD_W-1 -: REM_STEP], divisor);
         mag_in[k] = mag_ff[k-1] << REM_STEP;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (advance[k]) begin
            rem_ff[k] <= rem_in[k];
            mag_ff[k] <= mag_in[k];
         end
      end
   end

   assign remainder = rem_ff[STAGES-1];

endmodule

### hdl/texture_wrap_sampler.sv
// Texture wrap sampler top level: register port, lookup pipeline, texel memory.
// Depends on tws_pkg, tws_req_if, tws_rsp_if and tws_rem.
//
//   channel  direction  carries                                      transfer
//   req      in         action, texel_index, texel_rgb, coord_x/y    valid & ready
//   rsp      out        color_rgb, from_background (lookups only)    valid & ready
//   apb      in/out     image size, wrap mode, background, shifts    psel & penable
//
// One transaction is taken every cycle unless a waiting response backs the pipeline up to its input; a lookup
// passes the shift, scale, round, offset, remainder, fold, address and read stages in order.
// Loads write the texel memory at the same stage where lookups read it, so order holds.
// Reset clears the registers and the pipeline valid bits; the memory is left as it is.
// A waiting response holds only the stages behind it that are full; bubbles close up.
module texture_wrap_sampler import tws_pkg::*; #(
   parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
   parameter int COORD_FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   tws_req_if.sink               req,
   tws_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LD_W       = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
   localparam int SUM_W      = (ADDR_W > 2 * SIZE_W) ? ADDR_W : 2 * SIZE_W;
   localparam int XY_W       = COORD_W + 2;
   localparam int RND_W      = PROD_W + 1;
   localparam int MAG_W      = RND_W - COORD_FRAC_BITS;
   localparam int RND_HALF   = 1 << (COORD_FRAC_BITS - 1);
   localparam int REM_STAGES = (MAG_W + REM_STEP - 1) / REM_STEP;
   localparam int ST_B       = 1;
   localparam int ST_C       = 2;
   localparam int ST_D       = 3;
   localparam int ST_E       = ST_D + REM_STAGES + 1;
   localparam int ST_F       = ST_E + 1;
   localparam int ST_G       = ST_F + 1;
   localparam int NS         = ST_G + 1;

   typedef struct packed {
      logic              valid;
      logic              lookup;
      logic              load_ok;
      logic              bg;
      logic              neg_x;
      logic              neg_y;
      logic [ADDR_W-1:0] addr;
      logic [RGB_W-1:0]  rgb;
   } side_type;

   // ---------------- register port ----------------
   logic [SIZE_W-1:0]         width_ff, height_ff;
   logic [MODE_W-1:0]         mode_ff;
   logic [RGB_W-1:0]          bg_rgb_ff;
   logic signed [COORD_W-1:0] shift_x_ff, shift_y_ff;
   reg_index_type             reg_sel;
   logic                      csr_write;

   assign reg_sel   = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= SIZE_W'(RESET_SIZE);
         height_ff  <= SIZE_W'(RESET_SIZE);
         mode_ff    <= WRAP_BACKGROUND;
         bg_rgb_ff  <= '0;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_IMAGE_WIDTH:    width_ff   <= pwdata[SIZE_W-1:0];
            REG_IMAGE_HEIGHT:   height_ff  <= pwdata[SIZE_W-1:0];
            REG_WRAP_MODE:      mode_ff    <= pwdata[MODE_W-1:0];
            REG_BACKGROUND_RGB: bg_rgb_ff  <= pwdata[RGB_W-1:0];
            REG_SHIFT_X:        shift_x_ff <= $signed(pwdata[COORD_W-1:0]);
            REG_SHIFT_Y:        shift_y_ff <= $signed(pwdata[COORD_W-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_IMAGE_WIDTH:    prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT:   prdata = CSR_DATA_W'(height_ff);
         REG_WRAP_MODE:      prdata = CSR_DATA_W'(mode_ff);
         REG_BACKGROUND_RGB: prdata = CSR_DATA_W'(bg_rgb_ff);
         REG_SHIFT_X:        prdata = CSR_DATA_W'($unsigned(shift_x_ff));
         REG_SHIFT_Y:        prdata = CSR_DATA_W'($unsigned(shift_y_ff));
         default:            prdata = '0;
      endcase
   end

   // ---------------- effective geometry ----------------
   logic [SIZE_W-1:0] w_eff, h_eff;
   logic [DIV_W-1:0]  div_x, div_y;
   logic              mirror;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = SIZE_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = SIZE_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = SIZE_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_eff = SIZE_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      mirror = (mode_ff != WRAP_TILE);
      div_x  = mirror ? {w_eff, 1'b0} : {1'b0, w_eff};
      div_y  = mirror ? {h_eff, 1'b0} : {1'b0, h_eff};
   end

   // ---------------- pipeline control ----------------
   side_type    side_ff [NS];
   side_type    side_in [NS];
   logic [NS-1:0] ld;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      ld[NS-1] = !side_ff[NS-1].valid || !side_ff[NS-1].lookup || rsp.ready;
      for (int k = NS - 2; k >= 0; k--) begin
         ld[k] = !side_ff[k].valid || ld[k+1];
      end
   end

   assign req.ready = ld[0];

   // ---------------- datapath registers ----------------
   logic signed [XY_W-1:0]   x_ff, y_ff, x_in, y_in;
   logic signed [PROD_W-1:0] px_ff, py_ff, px_in, py_in;
   logic [PROD_W-1:0]        pabs_x, pabs_y;
   logic [RND_W-1:0]         rnd_x, rnd_y;
   logic [MAG_W-1:0]         rx_ff, ry_ff;
   logic                     pnx_ff, pny_ff;
   logic [MAG_W-1:0]         half;
   logic [MAG_W-1:0]         magx_in, magy_in, magx_ff, magy_ff;
   logic                     negx_in, negy_in;
   logic [DIV_W-1:0]         remx, remy;
   logic [SIZE_W-1:0]        ix_ff, iy_ff, ix_in, iy_in;
   logic [SUM_W-1:0]         addr_sum;
   logic [LD_W-1:0]          ld_index;
   logic [RGB_W-1:0]         rd_ff;
   logic [RGB_W-1:0]         texel_store [DEPTH];

   function automatic logic [SIZE_W-1:0] fold_index(logic [DIV_W-1:0] rem, logic neg,
                                                    logic [DIV_W-1:0] div,
                                                    logic [SIZE_W-1:0] size,
                                                    logic mirror_on);
      logic [DIV_W-1:0] m;
      m = (neg && rem != '0) ? div - rem : rem;
      if (mirror_on && m >= {1'b0, size}) begin
         m = div - DIV_W'(1) - m;
      end
      return m[SIZE_W-1:0];
   endfunction

   // index magnitude and sign after the half-size offset
   function automatic logic [MAG_W:0] offset_index(logic [MAG_W-1:0] r, logic pneg,
                                                   logic [MAG_W-1:0] h);
      logic [MAG_W:0] res;
      if (pneg && r > h) begin
         res = {1'b1, r - h};
      end else if (pneg) begin
         res = {1'b0, h - r};
      end else begin
         res = {1'b0, r + h};
      end
      return res;
   endfunction

   always_comb begin
      x_in     = -(XY_W'(req.coord_x) + XY_W'(shift_x_ff));
      y_in     = XY_W'(req.coord_y) + XY_W'(shift_y_ff);
      px_in    = x_ff * $signed({1'b0, w_eff});
      py_in    = y_ff * $signed({1'b0, h_eff});
      pabs_x   = px_ff[PROD_W-1] ? $unsigned(-px_ff) : $unsigned(px_ff);
      pabs_y   = py_ff[PROD_W-1] ? $unsigned(-py_ff) : $unsigned(py_ff);
      rnd_x    = (RND_W'(pabs_x) + RND_W'(RND_HALF)) >> COORD_FRAC_BITS;
      rnd_y    = (RND_W'(pabs_y) + RND_W'(RND_HALF)) >> COORD_FRAC_BITS;
      half     = MAG_W'(w_eff[SIZE_W-1:1]);
      {negx_in, magx_in} = offset_index(rx_ff, pnx_ff, half);
      half     = MAG_W'(h_eff[SIZE_W-1:1]);
      {negy_in, magy_in} = offset_index(ry_ff, pny_ff, half);
      ix_in    = fold_index(remx, side_ff[ST_E-1].neg_x, div_x, w_eff, mirror);
      iy_in    = fold_index(remy, side_ff[ST_E-1].neg_y, div_y, h_eff, mirror);
      addr_sum = SUM_W'(iy_ff) * SUM_W'(w_eff) + SUM_W'(ix_ff);
      ld_index = LD_W'(req.texel_index);
   end

   always_comb begin
      side_in[0].valid   = req.valid;
      side_in[0].lookup  = (req.action == ACT_LOOKUP);
      side_in[0].load_ok = {1'b0, ld_index} < (LD_W + 1)'(DEPTH);
      side_in[0].bg      = 1'b0;
      side_in[0].neg_x   = 1'b0;
      side_in[0].neg_y   = 1'b0;
      side_in[0].addr    = ld_index[ADDR_W-1:0];
      side_in[0].rgb     = req.texel_rgb;
      for (int k = 1; k < NS; k++) begin
         side_in[k] = side_ff[k-1];
      end
      side_in[ST_D].neg_x = negx_in;
      side_in[ST_D].neg_y = negy_in;
      side_in[ST_D].bg    = side_ff[ST_C].lookup && (mode_ff == WRAP_BACKGROUND)
                            && (negx_in || magx_in >= MAG_W'(w_eff)
                                || negy_in || magy_in >= MAG_W'(h_eff));
      if (side_ff[ST_E].lookup) begin
         side_in[ST_F].addr = addr_sum[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (reset) begin
            side_ff[k].valid <= 1'b0;
         end else if (ld[k]) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (ld[ST_B]) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
      if (ld[ST_C]) begin
         rx_ff  <= rnd_x[MAG_W-1:0];
         ry_ff  <= rnd_y[MAG_W-1:0];
         pnx_ff <= px_ff[PROD_W-1];
         pny_ff <= py_ff[PROD_W-1];
      end
      if (ld[ST_D]) begin
         magx_ff <= magx_in;
         magy_ff <= magy_in;
      end
      if (ld[ST_E]) begin
         ix_ff <= ix_in;
         iy_ff <= iy_in;
      end
   end

   tws_rem #(.MAG_W(MAG_W), .STAGES(REM_STAGES)) u_rem_x (
      .clock     (clock),
      .advance   (ld[ST_D+1 +: REM_STAGES]),
      .value     (magx_ff),
      .divisor   (div_x),
      .remainder (remx)
   );

   tws_rem #(.MAG_W(MAG_W), .STAGES(REM_STAGES)) u_rem_y (
      .clock     (clock),
      .advance   (ld[ST_D+1 +: REM_STAGES]),
      .value     (magy_ff),
      .divisor   (div_y),
      .remainder (remy)
   );

   // texel memory: one read and at most one write per cycle while the last stage advances, in pipeline order
   always_ff @(posedge clock) begin
      if (ld[ST_G]) begin
         rd_ff <= texel_store[side_ff[ST_F].addr];
         if (side_ff[ST_F].valid && !side_ff[ST_F].lookup && side_ff[ST_F].load_ok) begin
            texel_store[side_ff[ST_F].addr] <= side_ff[ST_F].rgb;
         end
      end
   end

   assign rsp.valid           = side_ff[ST_G].valid && side_ff[ST_G].lookup;
   assign rsp.from_background = side_ff[ST_G].bg;
   assign rsp.color_rgb       = side_ff[ST_G].bg ? bg_rgb_ff : rd_ff;

   // ---------------- assertions ----------------
   a_blocked_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid && !rsp.ready)
      else $error("request side blocked without a stalled response");

   a_read_data_held: assert property (@(posedge clock) disable iff (reset)
      side_ff[ST_G].valid && !ld[ST_G] |=> $stable(rsp.color_rgb) && $stable(side_ff[ST_G]))
      else $error("output stage changed while held");

endmodule

### test/texture_wrap_sampler_tb.sv
// Self-checking bench for texture_wrap_sampler: drives loads and lookups, programs the APB
// registers between phases and checks every response against a scoreboard prediction.
// Depends on tws_pkg, tws_req_if, tws_rsp_if and the sampler RTL.
`timescale 1ns / 100ps

module texture_wrap_sampler_tb;
   import tws_pkg::*;

   localparam int RESET_CYCLES    = 12;
   localparam int LATENCY_SLACK   = 24;      // pipeline is 13 deep, allow for bubbles
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int IDLE_PERCENT    = 13;
   localparam int PHASE_ITEMS     = 140;
   localparam int STORE_DEPTH     = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
   localparam logic [MODE_W-1:0] WRAP_SPARE = 2'd3;   // undefined code, behaves as mirror

   typedef struct {
      logic [SIZE_W-1:0]         width;
      logic [SIZE_W-1:0]         height;
      logic [MODE_W-1:0]         mode;
      logic [RGB_W-1:0]          background;
      logic signed [COORD_W-1:0] shift_x;
      logic signed [COORD_W-1:0] shift_y;
   } image_setting_type;

   class sampler_scoreboard;
      typedef struct {
         logic [RGB_W-1:0] color;
         logic             from_bg;
      } sample_type;

      logic [RGB_W-1:0]          texel_mem [STORE_DEPTH];
      logic [SIZE_W-1:0]         width_reg;
      logic [SIZE_W-1:0]         height_reg;
      logic [MODE_W-1:0]         mode_reg;
      logic [RGB_W-1:0]          background_reg;
      logic signed [COORD_W-1:0] shift_x_reg;
      logic signed [COORD_W-1:0] shift_y_reg;
      sample_type                samples_due [$];
      int                        errors;

      function new();
         width_reg      = SIZE_W'(RESET_SIZE);
         height_reg     = SIZE_W'(RESET_SIZE);
         mode_reg       = WRAP_BACKGROUND;
         background_reg = '0;
         shift_x_reg    = '0;
         shift_y_reg    = '0;
         errors         = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_IMAGE_WIDTH:    width_reg      = data[SIZE_W-1:0];
            REG_IMAGE_HEIGHT:   height_reg     = data[SIZE_W-1:0];
            REG_WRAP_MODE:      mode_reg       = data[MODE_W-1:0];
            REG_BACKGROUND_RGB: background_reg = data[RGB_W-1:0];
            REG_SHIFT_X:        shift_x_reg    = data[COORD_W-1:0];
            REG_SHIFT_Y:        shift_y_reg    = data[COORD_W-1:0];
            default: ;
         endcase
      endfunction

      // Zero acts as one, anything above the store dimension saturates.
      function longint eff_size(logic [SIZE_W-1:0] s, longint limit);
         if (s == 0) return 1;
         if (longint'(s) > limit) return limit;
         return longint'(s);
      endfunction

      function int image_texels();
         return int'(eff_size(width_reg, DEF_MAX_WIDTH) * eff_size(height_reg, DEF_MAX_HEIGHT));
      endfunction

      // Scale by size, round half away from zero, centre on size/2.
      function longint scaled_index(longint c, longint size);
         longint p;
         longint mag;
         longint r;
         p   = c * size;
         mag = (p < 0) ? -p : p;
         r   = (mag + (longint'(1) << (DEF_FRAC_BITS - 1))) >>> DEF_FRAC_BITS;
         return ((p < 0) ? -r : r) + size / 2;
      endfunction

      function longint fold_index(longint i, longint size);
         longint m;
         longint two;
         if (mode_reg == WRAP_TILE) begin
            m = i % size;
            if (m < 0) m += size;
         end else begin
            two = 2 * size;
            m = i % two;
            if (m < 0) m += two;
            if (m >= size) m = two - 1 - m;
         end
         return m;
      endfunction

      // Store position a lookup reads, or -1 when the background colour is returned.
      function int lookup_position(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy);
         longint w;
         longint h;
         longint ix;
         longint iy;
         bit     outside;
         w  = eff_size(width_reg, DEF_MAX_WIDTH);
         h  = eff_size(height_reg, DEF_MAX_HEIGHT);
         ix = scaled_index(-(longint'(cx) + longint'(shift_x_reg)), w);
         iy = scaled_index(longint'(cy) + longint'(shift_y_reg), h);
         outside = (ix < 0) || (ix >= w) || (iy < 0) || (iy >= h);
         if (outside && mode_reg == WRAP_BACKGROUND) return -1;
         if (ix < 0 || ix >= w) ix = fold_index(ix, w);
         if (iy < 0 || iy >= h) iy = fold_index(iy, h);
         return int'(w * iy + ix);
      endfunction

      function void note_request(action_type act, logic [INDEX_W-1:0] idx,
                                 logic [RGB_W-1:0] rgb, logic signed [COORD_W-1:0] cx,
                                 logic signed [COORD_W-1:0] cy);
         sample_type s;
         int         pos;
         if (act == ACT_LOAD) begin
            texel_mem[idx] = rgb;
         end else begin
            pos = lookup_position(cx, cy);
            if (pos < 0) begin
               s.color   = background_reg;
               s.from_bg = 1'b1;
            end else begin
               s.color   = texel_mem[pos];
               s.from_bg = 1'b0;
            end
            samples_due.push_back(s);
         end
      endfunction

      function void check_result(logic [RGB_W-1:0] color, logic from_bg);
         sample_type s;
         if (samples_due.size() == 0) begin
            $display("%0t unexpected response: colour %h background %b", $time, color, from_bg);
            errors++;
            return;
         end
         s = samples_due.pop_front();
         if (color !== s.color) begin
            $display("%0t color_rgb mismatch: expected %h, actual %h", $time, s.color, color);
            errors++;
         end
         if (from_bg !== s.from_bg) begin
            $display("%0t from_background mismatch: expected %b, actual %b",
                     $time, s.from_bg, from_bg);
            errors++;
         end
      endfunction

      function int pending();
         return samples_due.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   tws_req_if req_if ();
   tws_rsp_if rsp_if ();

   texture_wrap_sampler u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   sampler_scoreboard sb;
   bit                texel_loaded [STORE_DEPTH];
   bit                calm;        // no idling on either side while set
   bit                hold_req;    // ask the receiver for one long hold-off
   int                cycle_count;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.note_request(req_if.action, req_if.texel_index, req_if.texel_rgb,
                         req_if.coord_x, req_if.coord_y);
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.color_rgb, rsp_if.from_background);
   end

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin
      int hold_left;
      bit hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t timeout after %0d cycles, %0d responses outstanding",
               $time, cycle_count, sb.pending());
      $display("texture_wrap_sampler_tb: done, errors");
      $finish;
   end

   task automatic apb_write(reg_index_type idx, logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.write_reg(idx, data);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_image(image_setting_type s);
      apb_write(REG_IMAGE_WIDTH, CSR_DATA_W'(s.width));
      apb_write(REG_IMAGE_HEIGHT, CSR_DATA_W'(s.height));
      apb_write(REG_WRAP_MODE, CSR_DATA_W'(s.mode));
      apb_write(REG_BACKGROUND_RGB, CSR_DATA_W'(s.background));
      apb_write(REG_SHIFT_X, CSR_DATA_W'(s.shift_x));
      apb_write(REG_SHIFT_Y, CSR_DATA_W'(s.shift_y));
   endtask

   // Leaves valid high after the transaction so the next one can follow directly.
   task automatic send_item(action_type act, logic [INDEX_W-1:0] idx, logic [RGB_W-1:0] rgb,
                            logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.texel_index <= idx;
      req_if.texel_rgb   <= rgb;
      req_if.coord_x     <= cx;
      req_if.coord_y     <= cy;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (act == ACT_LOAD) texel_loaded[idx] = 1'b1;
   endtask

   // Fill the texel a lookup will read first, so no unwritten entry is ever sampled.
   task automatic send_lookup(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy);
      int pos;
      pos = sb.lookup_position(cx, cy);
      if (pos >= 0 && !texel_loaded[pos])
         send_item(ACT_LOAD, INDEX_W'(pos), RGB_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom));
      send_item(ACT_LOOKUP, INDEX_W'($urandom), RGB_W'($urandom), cx, cy);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   // Coordinate whose shifted value mostly lands in or near the image.
   function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] shift,
                                                           longint size);
      longint t;
      longint c;
      int     kind;
      kind = $urandom_range(9);
      if (kind <= 5) begin
         t = longint'($urandom_range(6 * 32768)) - 3 * 32768;
      end else if (kind <= 7) begin
         // odd multiples of a half texel: exact ties where the size is a power of two
         t = ((2 * longint'($urandom_range(4 * int'(size))) - 4 * size + 1) * 32768) / size;
      end else begin
         return COORD_W'($urandom);
      end
      c = t - longint'(shift);
      if (c < -(longint'(1) << (COORD_W - 1)) || c >= (longint'(1) << (COORD_W - 1))) c = t;
      return COORD_W'(c);
   endfunction

   task automatic random_items(int count, image_setting_type s);
      longint w;
      longint h;
      int     texels;
      int     pos;
      w      = sb.eff_size(s.width, DEF_MAX_WIDTH);
      h      = sb.eff_size(s.height, DEF_MAX_HEIGHT);
      texels = sb.image_texels();
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 40) begin
            pos = ($urandom_range(99) < 75) ? int'($urandom_range(texels - 1))
                                            : int'($urandom_range(STORE_DEPTH - 1));
            send_item(ACT_LOAD, INDEX_W'(pos), RGB_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom));
         end else begin
            send_lookup(pick_coord(s.shift_x, w), pick_coord(s.shift_y, h));
         end
      end
   endtask

   task automatic directed_items();
      send_item(ACT_LOAD, 16'h0000, 24'hFFFFFF, 24'sh7FFFFF, -24'sh800000);
      send_item(ACT_LOAD, 16'hFFFF, 24'h000000, 24'sh000000, 24'sh000000);
      send_item(ACT_LOAD, 16'h8080, 24'hA55A3C, -24'sh000001, 24'sh123456);
      send_lookup(24'sd0, 24'sd0);                     // centre texel
      send_lookup(24'sd32768, -24'sd32768);            // first texel
      send_lookup(-24'sd32512, 24'sd32512);            // last texel
      send_lookup(-24'sd32768, 24'sd0);                // one column right of the image
      send_lookup(24'sd0, 24'sd32768);                 // one row below
      send_lookup(24'sd0, -24'sd32896);                // tie rounds away, falls above
      send_lookup(24'sd0, 24'sd32640);                 // tie rounds away, falls below
      send_lookup(24'sd0, 24'sd32639);                 // just under the tie
      send_lookup(-24'sd128, 24'sd0);                  // positive half texel
      send_lookup(24'sd128, 24'sd0);                   // negative half texel
      send_lookup(24'sd1, -24'sd1);                    // rounds to minus zero
      send_lookup(-24'sh800000, 24'sh7FFFFF);
      send_lookup(24'sh7FFFFF, -24'sh800000);
   endtask

   initial begin
      image_setting_type settings [$];
      sb = new();
      reset          <= 1'b1;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      req_if.valid       <= 1'b0;
      req_if.action      <= ACT_LOAD;
      req_if.texel_index <= '0;
      req_if.texel_rgb   <= '0;
      req_if.coord_x     <= '0;
      req_if.coord_y     <= '0;
      calm     = 1'b0;
      hold_req = 1'b0;

      settings.push_back('{9'd256, 9'd256, WRAP_BACKGROUND, 24'h5A3C96, 24'sd0, 24'sd0});
      settings.push_back('{9'd8, 9'd4, WRAP_TILE, 24'h000000, 24'sh001234, -24'sh002000});
      settings.push_back('{9'd5, 9'd3, WRAP_MIRROR, 24'hFFFFFF, -24'sh008000, 24'sh018000});
      settings.push_back('{9'd0, 9'd0, WRAP_SPARE, 24'h00FF00, 24'sh000100, -24'sh000100});
      settings.push_back('{9'd511, 9'd300, WRAP_TILE, 24'h123456, 24'sh7FFFFF, -24'sh800000});
      settings.push_back('{9'd1, 9'd256, WRAP_MIRROR, 24'h0F0F0F, -24'sh800000, 24'sh7FFFFF});
      settings.push_back('{9'd256, 9'd1, WRAP_BACKGROUND, 24'hFFFFFF, 24'sh010000,
                           -24'sh010000});
      settings.push_back('{9'd17, 9'd13, WRAP_TILE, RGB_W'($urandom), COORD_W'($urandom),
                           COORD_W'($urandom)});
      settings.push_back('{9'd3, 9'd7, WRAP_MIRROR, RGB_W'($urandom), -24'sh030000,
                           24'sh050000});
      settings.push_back('{9'd64, 9'd48, WRAP_BACKGROUND, 24'h000000, 24'sh004321,
                           -24'sh001111});
      settings.push_back('{9'd256, 9'd256, WRAP_MIRROR, 24'h808080, 24'sh400000,
                           -24'sh400000});

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (settings[p]) begin
         wait_drained();
         set_image(settings[p]);
         calm = (p == 6);
         if (p == 0) directed_items();
         if (p == 2) hold_req = 1'b1;
         if (p == 3) begin
            random_items(80, settings[p]);
            wait_drained();
            random_items(PHASE_ITEMS - 80, settings[p]);
         end else begin
            random_items(PHASE_ITEMS, settings[p]);
         end
      end
      calm = 1'b0;
      wait_drained();

      if (sb.errors == 0)
         $display("texture_wrap_sampler_tb: done, clean");
      else
         $display("texture_wrap_sampler_tb: done, errors");
      $finish;
   end

endmodule

### filelist.f
hdl/tws_pkg.sv
hdl/tws_chan_if.sv
hdl/tws_rem.sv
hdl/texture_wrap_sampler.sv
test/texture_wrap_sampler_tb.sv
